// File: rtl/osm_pkg.sv
// osm_pkg: shared constants and types for the order statistic multiset
// no dependencies; compiled before the interfaces and the core

package osm_pkg;

    localparam int CAPACITY = 64;
    localparam int AW       = $clog2(CAPACITY);
    localparam int CW       = $clog2(CAPACITY + 1);

    localparam int KW  = 48;
    localparam int NW  = 16;
    localparam int TW  = 22;

    localparam logic [NW-1:0] MAX_COUNT = {NW{1'b1}};

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_ERASE  = 3'd1;
    localparam logic [2:0] OP_FIND   = 3'd2;
    localparam logic [2:0] OP_LOWER  = 3'd3;
    localparam logic [2:0] OP_SELECT = 3'd4;
    localparam logic [2:0] OP_POS    = 3'd5;
    localparam logic [2:0] OP_ADD    = 3'd6;
    localparam logic [2:0] OP_CLEAR  = 3'd7;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_MISSING  = 2'd2;
    localparam logic [1:0] ST_SATURATE = 2'd3;

    typedef struct packed {
        logic [KW-1:0] key;
        logic [NW-1:0] cnt;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_ACT,
        S_SHR_RD,
        S_SHR_WR,
        S_SHL_RD,
        S_SHL_WR,
        S_SAT,
        S_DONE
    } state_t;

endpackage

// File: rtl/osm_if.sv
// osm_req_if and osm_rsp_if: valid/ready channels of the multiset core
// no dependencies

interface osm_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [31:0] key;
    logic [7:0]  times;
    logic [21:0] index;

    modport source (output valid, op, key, times, index, input ready);
    modport sink   (input valid, op, key, times, index, output ready);
endinterface

interface osm_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] value;
    logic [21:0] rank;
    logic [21:0] total_size;
    logic [1:0]  status;

    modport source (output valid, found, value, rank, total_size, status, input ready);
    modport sink   (input valid, found, value, rank, total_size, status, output ready);
endinterface

// File: rtl/order_statistic_multiset_core.sv
// order_statistic_multiset_core: sorted key/count memory with a sequencer
// depends on osm_pkg and the osm_req_if / osm_rsp_if interfaces
//
// usage
//   req carries one operation per beat (op, key, times, index); rsp returns
//   exactly one result beat per request (found, value, rank, total_size,
//   status). one request is worked on at a time; req.ready is high while
//   the sequencer is idle.
//   keys and counts sit in one single-port synchronous memory of CAPACITY
//   entries in ascending order. each entry visited takes a read state and
//   then a compare state (S_RD, S_CMP), up to the position where the
//   search stops. insert of a new key and removing erase then shift the
//   tail one entry at a time, a read state then a write state per entry.
//   add to all, clear and select out of range skip the search and go
//   straight to the result.
//   the result is held in an output register; while rsp is stalled the
//   next request is still worked on and waits at its end until the
//   output register frees.
//   reset empties the set and zeroes the offset at once; the memory is
//   not cleared, entries beyond the used count are never read.

module order_statistic_multiset_core
    import osm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    osm_req_if.sink    req,
    osm_rsp_if.source  rsp
);

    entry_t mem [CAPACITY];
    entry_t rd_q;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_addr;
    entry_t        mem_wdata;

    state_t state_reg, state_next;
    logic [2:0]    op_reg, op_next;
    logic [KW-1:0] q_reg, q_next;
    logic [7:0]    times_reg, times_next;
    logic [TW-1:0] rem_reg, rem_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] i_reg, i_next;
    logic [TW-1:0] before_reg, before_next;
    logic          exact_reg, exact_next;
    logic [NW-1:0] hit_cnt_reg, hit_cnt_next;
    logic [KW-1:0] eff_reg, eff_next;
    logic [CW-1:0] used_reg, used_next;
    logic [TW-1:0] total_reg, total_next;
    logic [KW-1:0] offset_reg, offset_next;
    logic          found_reg, found_next;
    logic [31:0]   value_reg, value_next;
    logic [TW-1:0] rank_reg, rank_next;
    logic [1:0]    status_reg, status_next;

    logic          rsp_valid_reg, rsp_valid_next;
    logic          rsp_found_reg, rsp_found_next;
    logic [31:0]   rsp_value_reg, rsp_value_next;
    logic [TW-1:0] rsp_rank_reg, rsp_rank_next;
    logic [TW-1:0] rsp_total_reg, rsp_total_next;
    logic [1:0]    rsp_status_reg, rsp_status_next;

    logic [KW-1:0] k48;
    logic [NW:0]   cnt_sum;

    assign k48     = {{(KW-32){req.key[31]}}, req.key};
    assign cnt_sum = {1'b0, hit_cnt_reg} + {{(NW-7){1'b0}}, times_reg};

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.found      = rsp_found_reg;
    assign rsp.value      = rsp_value_reg;
    assign rsp.rank       = rsp_rank_reg;
    assign rsp.total_size = rsp_total_reg;
    assign rsp.status     = rsp_status_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_q <= mem[mem_addr];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        q_next          = q_reg;
        times_next      = times_reg;
        rem_next        = rem_reg;
        pos_next        = pos_reg;
        i_next          = i_reg;
        before_next     = before_reg;
        exact_next      = exact_reg;
        hit_cnt_next    = hit_cnt_reg;
        eff_next        = eff_reg;
        used_next       = used_reg;
        total_next      = total_reg;
        offset_next     = offset_reg;
        found_next      = found_reg;
        value_next      = value_reg;
        rank_next       = rank_reg;
        status_next     = status_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_found_next  = rsp_found_reg;
        rsp_value_next  = rsp_value_reg;
        rsp_rank_next   = rsp_rank_reg;
        rsp_total_next  = rsp_total_reg;
        rsp_status_next = rsp_status_reg;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = pos_reg[AW-1:0];
        mem_wdata = rd_q;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next     = req.op;
                    q_next      = k48 - offset_reg;
                    times_next  = req.times;
                    rem_next    = req.index;
                    pos_next    = '0;
                    before_next = '0;
                    found_next  = 1'b0;
                    value_next  = '0;
                    rank_next   = '0;
                    status_next = ST_OK;
                    state_next  = S_RD;
                    case (req.op)
                        OP_ADD:
                        begin
                            if (used_reg != '0)
                            begin
                                offset_next = offset_reg + k48;
                            end
                            state_next = S_DONE;
                        end
                        OP_CLEAR:
                        begin
                            used_next   = '0;
                            total_next  = '0;
                            offset_next = '0;
                            state_next  = S_DONE;
                        end
                        OP_SELECT:
                        begin
                            if (req.index >= total_reg)
                            begin
                                status_next = ST_MISSING;
                                state_next  = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_RD;
                        end
                    endcase
                end
            end

            S_RD:
            begin
                if (pos_reg == used_reg)
                begin
                    // ran past the last entry: no exact match
                    exact_next = 1'b0;
                    state_next = S_ACT;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_CMP;
                end
            end

            S_CMP:
            begin
                if (op_reg == OP_SELECT)
                begin
                    if (rem_reg < TW'(rd_q.cnt))
                    begin
                        eff_next   = rd_q.key + offset_reg;
                        state_next = S_SAT;
                    end
                    else
                    begin
                        rem_next   = rem_reg - TW'(rd_q.cnt);
                        pos_next   = pos_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
                else if ($signed(rd_q.key) < $signed(q_reg))
                begin
                    before_next = before_reg + TW'(rd_q.cnt);
                    pos_next    = pos_reg + 1'b1;
                    state_next  = S_RD;
                end
                else
                begin
                    exact_next   = (rd_q.key == q_reg);
                    hit_cnt_next = rd_q.cnt;
                    state_next   = S_ACT;
                end
            end

            S_ACT:
            begin
                state_next = S_DONE;
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (times_reg == '0)
                        begin
                            status_next = ST_OK;
                        end
                        else if (exact_reg)
                        begin
                            mem_we = 1'b1;
                            mem_wdata.key = q_reg;
                            if (cnt_sum[NW])
                            begin
                                mem_wdata.cnt = MAX_COUNT;
                                status_next   = ST_SATURATE;
                                total_next    = total_reg + TW'(MAX_COUNT - hit_cnt_reg);
                            end
                            else
                            begin
                                mem_wdata.cnt = cnt_sum[NW-1:0];
                                total_next    = total_reg + TW'(times_reg);
                            end
                        end
                        else if (used_reg >= CW'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            i_next     = used_reg;
                            state_next = S_SHR_RD;
                        end
                    end
                    OP_ERASE:
                    begin
                        if (!exact_reg)
                        begin
                            status_next = ST_MISSING;
                        end
                        else if (NW'(times_reg) >= hit_cnt_reg)
                        begin
                            total_next = total_reg - TW'(hit_cnt_reg);
                            i_next     = pos_reg;
                            state_next = S_SHL_RD;
                        end
                        else
                        begin
                            mem_we        = 1'b1;
                            mem_wdata.key = q_reg;
                            mem_wdata.cnt = hit_cnt_reg - NW'(times_reg);
                            total_next    = total_reg - TW'(times_reg);
                        end
                    end
                    OP_FIND:
                    begin
                        found_next  = exact_reg;
                        status_next = exact_reg ? ST_OK : ST_MISSING;
                    end
                    OP_LOWER:
                    begin
                        rank_next = before_reg;
                    end
                    OP_POS:
                    begin
                        found_next  = exact_reg;
                        rank_next   = exact_reg ? before_reg : '0;
                        status_next = exact_reg ? ST_OK : ST_MISSING;
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end

            // open a slot at pos by moving the tail up one entry
            S_SHR_RD:
            begin
                if (i_reg == pos_reg)
                begin
                    mem_we        = 1'b1;
                    mem_addr      = pos_reg[AW-1:0];
                    mem_wdata.key = q_reg;
                    mem_wdata.cnt = NW'(times_reg);
                    used_next     = used_reg + 1'b1;
                    total_next    = total_reg + TW'(times_reg);
                    state_next    = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_addr   = AW'(i_reg - 1'b1);
                    state_next = S_SHR_WR;
                end
            end

            S_SHR_WR:
            begin
                mem_we     = 1'b1;
                mem_addr   = i_reg[AW-1:0];
                mem_wdata  = rd_q;
                i_next     = i_reg - 1'b1;
                state_next = S_SHR_RD;
            end

            // close the gap at pos by moving the tail down one entry
            S_SHL_RD:
            begin
                if ((CW+1)'(i_reg) + 1'b1 >= (CW+1)'(used_reg))
                begin
                    used_next  = used_reg - 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_addr   = AW'(i_reg + 1'b1);
                    state_next = S_SHL_WR;
                end
            end

            S_SHL_WR:
            begin
                mem_we     = 1'b1;
                mem_addr   = i_reg[AW-1:0];
                mem_wdata  = rd_q;
                i_next     = i_reg + 1'b1;
                state_next = S_SHL_RD;
            end

            S_SAT:
            begin
                found_next = 1'b1;
                if ($signed(eff_reg) < -$signed(KW'(64'h8000_0000)))
                begin
                    value_next = 32'h8000_0000;
                end
                else if ($signed(eff_reg) > $signed(KW'(64'h7FFF_FFFF)))
                begin
                    value_next = 32'h7FFF_FFFF;
                end
                else
                begin
                    value_next = eff_reg[31:0];
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_found_next  = found_reg;
                    rsp_value_next  = value_reg;
                    rsp_rank_next   = rank_reg;
                    rsp_total_next  = total_reg;
                    rsp_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            total_reg     <= '0;
            offset_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            total_reg     <= total_next;
            offset_reg    <= offset_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        q_reg          <= q_next;
        times_reg      <= times_next;
        rem_reg        <= rem_next;
        pos_reg        <= pos_next;
        i_reg          <= i_next;
        before_reg     <= before_next;
        exact_reg      <= exact_next;
        hit_cnt_reg    <= hit_cnt_next;
        eff_reg        <= eff_next;
        found_reg      <= found_next;
        value_reg      <= value_next;
        rank_reg       <= rank_next;
        status_reg     <= status_next;
        rsp_found_reg  <= rsp_found_next;
        rsp_value_reg  <= rsp_value_next;
        rsp_rank_reg   <= rsp_rank_next;
        rsp_total_reg  <= rsp_total_next;
        rsp_status_reg <= rsp_status_next;
    end

`ifndef SYNTH
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(CAPACITY))
        else $error("distinct count above capacity");

    // on a removing erase the total drops in S_ACT, before the used count drops at the end of the shift
    a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ((used_reg == '0) == (total_reg == '0)))
        else $error("element total disagrees with distinct count");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD || state_reg == S_CMP) |-> pos_reg <= used_reg)
        else $error("search ran beyond used entries");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> state_reg != S_IDLE)
        else $error("accepted beat did not start work");
`endif

endmodule
